FILE: sv/i2c_bit_level_master_macros.svh
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define I2CM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define I2CM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned TicksW = 16;
  localparam int unsigned PhaseW = 5;
  localparam logic [TicksW-1:0] TicksReset = 16'd10;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [PhaseW-1:0] phase;
    logic [TicksW-1:0] ticks;
    logic [7:0]        shift;
    logic              scl;
    logic              sda;
    logic              ack;
    logic              drive_ack;
    logic [7:0]        read_byte;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       rejected;
  } res_t;

  function automatic logic [PhaseW-1:0] seq_len(cmd_e cmd);
    logic [PhaseW-1:0] len;
    unique case (cmd)
      CMD_START: len = 5'd4;
      CMD_STOP:  len = 5'd3;
      CMD_SEND:  len = 5'd24;
      CMD_RECV:  len = 5'd25;
      CMD_SACK:  len = 5'd3;
      CMD_RACK:  len = 5'd4;
      default:   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: sv/i2cm_req_if.sv
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic       ack_bit;
  logic       sda_in;

  modport source (output valid, req_type, data_byte, ack_bit, sda_in, input ready);
  modport sink (input valid, req_type, data_byte, ack_bit, sda_in, output ready);
endinterface

FILE: sv/i2cm_res_if.sv
interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_received;
  logic       rejected;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                  ack_received, rejected, input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                ack_received, rejected, output ready);
endinterface

FILE: sv/i2cm_cfg_if.sv
interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_ticks;

  modport source (output valid, phase_ticks, input ready);
  modport sink (input valid, phase_ticks, output ready);
endinterface

FILE: sv/i2cm_step.sv
module i2cm_step
  import i2cm_pkg::*;
(
  input  state_t            st_i,
  input  logic [TicksW-1:0] phase_ticks_i,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic              ack_bit_i,
  input  logic              sda_in_i,
  output state_t            st_o,
  output logic              done_o,
  output logic              rej_o
);

  function automatic state_t run_phase(state_t s, logic [PhaseW-1:0] p, logic sda);
    state_t            n;
    logic [PhaseW-1:0] v;
    logic [9:0]        prod;
    logic [PhaseW-1:0] q;
    logic [PhaseW-1:0] rem;
    logic [2:0]        bitn;
    n    = s;
    v    = (s.cmd == CMD_RECV) ? p - 5'd1 : p;
    prod = {5'd0, v} * 10'd11;
    q    = prod[9:5];
    rem  = v - 5'(q * 5'd3);
    bitn = q[2:0];
    unique case (s.cmd)
      CMD_START: begin
        unique case (p[1:0])
          2'd0:    n.sda = 1'b1;
          2'd1:    n.scl = 1'b1;
          2'd2:    n.sda = 1'b0;
          default: n.scl = 1'b0;
        endcase
      end
      CMD_STOP: begin
        if (p == 5'd0) n.sda = 1'b0;
        else if (p == 5'd1) n.scl = 1'b1;
        else n.sda = 1'b1;
      end
      CMD_SEND: begin
        if (rem == 5'd0) n.sda = s.shift[3'd7 - bitn];
        else if (rem == 5'd1) n.scl = 1'b1;
        else n.scl = 1'b0;
      end
      CMD_RECV: begin
        if (p == 5'd0) n.sda = 1'b1;
        else if (rem == 5'd0) n.scl = 1'b1;
        else if (rem == 5'd1) n.shift = sda ? (s.shift | (8'h80 >> bitn)) : s.shift;
        else n.scl = 1'b0;
      end
      CMD_SACK: begin
        if (p == 5'd0) n.sda = s.drive_ack;
        else if (p == 5'd1) n.scl = 1'b1;
        else n.scl = 1'b0;
      end
      CMD_RACK: begin
        unique case (p[1:0])
          2'd0:    n.sda = 1'b1;
          2'd1:    n.scl = 1'b1;
          2'd2:    n.ack = sda;
          default: n.scl = 1'b0;
        endcase
      end
      default: n = s;
    endcase
    return n;
  endfunction

  logic [TicksW-1:0] limit;
  logic [TicksW-1:0] tick;
  logic [PhaseW-1:0] ph;
  logic              is_cmd;
  state_t            nx;

  always_comb begin
    limit  = (phase_ticks_i == '0) ? 16'd1 : phase_ticks_i;
    is_cmd = (req_type_i >= CMD_START) && (req_type_i <= CMD_RACK);
    tick   = st_i.ticks + 16'd1;
    ph     = st_i.phase + 5'd1;
    nx     = st_i;
    done_o = 1'b0;
    rej_o  = 1'b0;
    if (st_i.cmd != CMD_IDLE) begin
      rej_o    = is_cmd;
      nx.ticks = tick;
      if (tick >= limit) begin
        nx.ticks = '0;
        nx.phase = ph;
        if (ph >= seq_len(st_i.cmd)) begin
          if (st_i.cmd == CMD_RECV) nx.read_byte = st_i.shift;
          nx.cmd   = CMD_IDLE;
          nx.phase = '0;
          done_o   = 1'b1;
        end else begin
          nx = run_phase(nx, ph, sda_in_i);
        end
      end
    end else if (is_cmd) begin
      nx.cmd   = cmd_e'(req_type_i);
      nx.phase = '0;
      nx.ticks = '0;
      if (nx.cmd == CMD_SEND) nx.shift = data_byte_i;
      else if (nx.cmd == CMD_RECV) nx.shift = 8'h00;
      if (nx.cmd == CMD_SACK) nx.drive_ack = ack_bit_i;
      nx = run_phase(nx, 5'd0, sda_in_i);
    end
    st_o = nx;
  end

endmodule

FILE: sv/i2cm_outbuf.sv
module i2cm_outbuf
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        res_i,
  output logic        full_o,
  i2cm_res_if.source  res_o
);

  logic valid_q;
  res_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign full_o             = valid_q;
  assign res_o.valid        = valid_q;
  assign res_o.scl_level    = data_q.scl_level;
  assign res_o.sda_level    = data_q.sda_level;
  assign res_o.busy_res     = data_q.busy_res;
  assign res_o.done_res     = data_q.done_res;
  assign res_o.read_byte    = data_q.read_byte;
  assign res_o.ack_received = data_q.ack_received;
  assign res_o.rejected     = data_q.rejected;

endmodule

FILE: sv/i2c_bit_level_master.sv
// Channel  Dir  Payload                                      Transfer
// req_i    in   req_type, data_byte, ack_bit, sda_in         valid & ready
// res_o    out  scl/sda levels, busy, done, read_byte, ack,  valid & ready
//               rejected
// cfg_i    in   phase_ticks                                  valid & ready
//
// One request per cycle while res_o is not stalled; its result is registered and shows in the next cycle.
// The line-phase step logic sits between the state registers and the result
// register, so throughput is set only by res_o stalls.
// A stalled result holds; req_i.ready stays high while res_o drains that cycle.
// Reset: idle, SCL and SDA released, phase_ticks 10, no result pending.
`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master
  import i2cm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_req_if.sink   req_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_res_if.source res_o
);

  state_t            st_q, st_d;
  logic [TicksW-1:0] phase_ticks_q;
  logic              full;
  logic              accept;
  logic              done;
  logic              rej;
  res_t              res_d;

  assign req_i.ready = !full || res_o.ready;
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;

  i2cm_step u_step (
    .st_i          (st_q),
    .phase_ticks_i (phase_ticks_q),
    .req_type_i    (req_i.req_type),
    .data_byte_i   (req_i.data_byte),
    .ack_bit_i     (req_i.ack_bit),
    .sda_in_i      (req_i.sda_in),
    .st_o          (st_d),
    .done_o        (done),
    .rej_o         (rej)
  );

  always_comb begin
    res_d.scl_level    = st_d.scl;
    res_d.sda_level    = st_d.sda;
    res_d.busy_res     = (st_d.cmd != CMD_IDLE);
    res_d.done_res     = done;
    res_d.read_byte    = st_d.read_byte;
    res_d.ack_received = st_d.ack;
    res_d.rejected     = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cmd       <= CMD_IDLE;
      st_q.phase     <= '0;
      st_q.ticks     <= '0;
      st_q.shift     <= '0;
      st_q.scl       <= 1'b1;
      st_q.sda       <= 1'b1;
      st_q.ack       <= 1'b1;
      st_q.drive_ack <= 1'b0;
      st_q.read_byte <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= TicksReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      phase_ticks_q <= cfg_i.phase_ticks;
    end
  end

  i2cm_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .res_i  (res_d),
    .full_o (full),
    .res_o  (res_o)
  );

  `I2CM_ASSERT_IMP(a_idle_clean, st_q.cmd == CMD_IDLE, st_q.phase == '0 && st_q.ticks == '0, "idle with phase or ticks set")
  `I2CM_ASSERT_IMP(a_phase_range, st_q.cmd != CMD_IDLE, st_q.phase < seq_len(st_q.cmd), "phase beyond command length")
  `I2CM_ASSERT_NXT(a_accept_result, accept, res_o.valid, "accepted request left no result")

endmodule

FILE: verif/tb_top.sv
module tb_top;
  import i2cm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_NOP  = 3'd7;

  typedef struct {
    logic [2:0] req;
    logic [7:0] data;
    logic       ack;
    logic       sda;
  } bus_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  i2cm_req_if req_if ();
  i2cm_cfg_if cfg_if ();
  i2cm_res_if res_if ();

  i2c_bit_level_master dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  bus_op_t     op_queue[$];
  res_t        line_results_due[$];
  int unsigned ops_queued = 0;
  int unsigned lines_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_used = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        req_took = 1'b0;

  cmd_e        cur_cmd   = CMD_IDLE;
  logic [4:0]  phase_no  = '0;
  logic [15:0] hold_cnt  = '0;
  logic [7:0]  shreg     = '0;
  logic        scl_q     = 1'b1;
  logic        sda_q     = 1'b1;
  logic        ack_q     = 1'b1;
  logic        ack_drv   = 1'b0;
  logic [7:0]  rd_q      = '0;
  logic [15:0] ticks_cfg = TicksReset;

  function automatic int unsigned phase_count(cmd_e c);
    case (c)
      CMD_START: return 4;
      CMD_STOP:  return 3;
      CMD_SEND:  return 24;
      CMD_RECV:  return 25;
      CMD_SACK:  return 3;
      CMD_RACK:  return 4;
      default:   return 0;
    endcase
  endfunction

  function automatic void drive_phase(int unsigned p, logic sda_now);
    int unsigned bitn;
    int unsigned r;
    case (cur_cmd)
      CMD_START: begin
        if (p == 0) sda_q = 1'b1;
        else if (p == 1) scl_q = 1'b1;
        else if (p == 2) sda_q = 1'b0;
        else scl_q = 1'b0;
      end
      CMD_STOP: begin
        if (p == 0) sda_q = 1'b0;
        else if (p == 1) scl_q = 1'b1;
        else sda_q = 1'b1;
      end
      CMD_SEND: begin
        bitn = (p / 3) % 8;
        r = p % 3;
        if (r == 0) sda_q = shreg[7 - bitn];
        else if (r == 1) scl_q = 1'b1;
        else scl_q = 1'b0;
      end
      CMD_RECV: begin
        if (p == 0) begin
          sda_q = 1'b1;
        end else begin
          bitn = ((p - 1) / 3) % 8;
          r = (p - 1) % 3;
          if (r == 0) scl_q = 1'b1;
          else if (r == 1) begin
            if (sda_now) shreg[7 - bitn] = 1'b1;
          end else scl_q = 1'b0;
        end
      end
      CMD_SACK: begin
        if (p == 0) sda_q = ack_drv;
        else if (p == 1) scl_q = 1'b1;
        else scl_q = 1'b0;
      end
      CMD_RACK: begin
        if (p == 0) sda_q = 1'b1;
        else if (p == 1) scl_q = 1'b1;
        else if (p == 2) ack_q = sda_now;
        else scl_q = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic res_t line_step(bus_op_t op);
    res_t        r;
    logic        is_cmd;
    logic        fin;
    logic        rej;
    logic [15:0] lim;
    is_cmd = (op.req != REQ_TICK) && (op.req != REQ_NOP);
    fin = 1'b0;
    rej = 1'b0;
    lim = (ticks_cfg == '0) ? 16'd1 : ticks_cfg;
    if (cur_cmd != CMD_IDLE) begin
      rej = is_cmd;
      hold_cnt = hold_cnt + 16'd1;
      if (hold_cnt >= lim) begin
        hold_cnt = '0;
        phase_no = phase_no + 5'd1;
        if (phase_no >= phase_count(cur_cmd)) begin
          if (cur_cmd == CMD_RECV) rd_q = shreg;
          cur_cmd = CMD_IDLE;
          phase_no = '0;
          fin = 1'b1;
        end else begin
          drive_phase(32'(phase_no), op.sda);
        end
      end
    end else if (is_cmd) begin
      cur_cmd = cmd_e'(op.req);
      phase_no = '0;
      hold_cnt = '0;
      if (cur_cmd == CMD_SEND) shreg = op.data;
      else if (cur_cmd == CMD_RECV) shreg = '0;
      if (cur_cmd == CMD_SACK) ack_drv = op.ack;
      drive_phase(0, op.sda);
    end
    r.scl_level    = scl_q;
    r.sda_level    = sda_q;
    r.busy_res     = (cur_cmd != CMD_IDLE);
    r.done_res     = fin;
    r.read_byte    = rd_q;
    r.ack_received = ack_q;
    r.rejected     = rej;
    return r;
  endfunction

  task automatic report(string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic queue_op(logic [2:0] req, logic [7:0] data, logic ack, logic sda);
    bus_op_t op;
    op.req = req;
    op.data = data;
    op.ack = ack;
    op.sda = sda;
    op_queue.push_back(op);
    ops_queued++;
  endtask

  task automatic queue_filler();
    logic [2:0] req;
    req = ($urandom_range(99) < 80) ? REQ_TICK : 3'($urandom_range(REQ_NOP, CMD_START));
    queue_op(req, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic queue_traffic(int unsigned n, logic [15:0] ticks);
    int unsigned made;
    int unsigned roll;
    int unsigned fill;
    int unsigned eff;
    cmd_e        cmd;
    eff = (ticks == '0) ? 1 : ticks;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        queue_op($urandom_range(1) ? REQ_NOP : REQ_TICK, 8'($urandom), 1'($urandom),
                 1'($urandom));
        made++;
      end else begin
        cmd = cmd_e'($urandom_range(CMD_RACK, CMD_START));
        fill = phase_count(cmd) * eff;
        if (roll < 22) fill = $urandom_range(fill - 1);
        queue_op(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat (fill) queue_filler();
        made += fill + 1;
      end
    end
  endtask

  task automatic settle();
    while (lines_seen < ops_queued) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_ticks(logic [15:0] v);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.phase_ticks <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned res_pct);
    send_idle_pct = send_pct;
    stall_pct = res_pct;
  endtask

  always @(negedge clk_i) begin
    bus_op_t op;
    if (!req_if.valid || req_took) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = op_queue.pop_front();
        req_if.valid     <= 1'b1;
        req_if.req_type  <= op.req;
        req_if.data_byte <= op.data;
        req_if.ack_bit   <= op.ack;
        req_if.sda_in    <= op.sda;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    res_t    got;
    res_t    want;
    bus_op_t op;
    req_took <= req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        lines_seen++;
        got.scl_level    = res_if.scl_level;
        got.sda_level    = res_if.sda_level;
        got.busy_res     = res_if.busy_res;
        got.done_res     = res_if.done_res;
        got.read_byte    = res_if.read_byte;
        got.ack_received = res_if.ack_received;
        got.rejected     = res_if.rejected;
        if (line_results_due.size() == 0) begin
          report("result transfer with no request outstanding");
        end else begin
          want = line_results_due.pop_front();
          check_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
          check_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
          check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          check_field("done_res", 8'(got.done_res), 8'(want.done_res));
          check_field("read_byte", got.read_byte, want.read_byte);
          check_field("ack_received", 8'(got.ack_received), 8'(want.ack_received));
          check_field("rejected", 8'(got.rejected), 8'(want.rejected));
        end
      end
      if (req_if.valid && req_if.ready) begin
        op.req  = req_if.req_type;
        op.data = req_if.data_byte;
        op.ack  = req_if.ack_bit;
        op.sda  = req_if.sda_in;
        line_results_due.push_back(line_step(op));
      end
      if (cfg_if.valid && cfg_if.ready) ticks_cfg = cfg_if.phase_ticks;
    end
  end

  initial begin
    #3_000_000;
    $display("FAIL i2c_bit_level_master");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_TICK;
    req_if.data_byte = '0;
    req_if.ack_bit = 1'b0;
    req_if.sda_in = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.phase_ticks = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset phase_ticks, tick and unused code while idle, then busy rejects
    queue_op(REQ_TICK, 8'h00, 1'b0, 1'b0);
    queue_op(REQ_NOP, 8'hFF, 1'b1, 1'b1);
    queue_op(CMD_SACK, 8'h5A, 1'b0, 1'b1);
    queue_op(CMD_START, 8'h00, 1'b1, 1'b0);
    queue_op(CMD_STOP, 8'hFF, 1'b0, 1'b1);
    queue_op(CMD_SEND, 8'h80, 1'b1, 1'b0);
    queue_op(CMD_RECV, 8'h7F, 1'b0, 1'b1);
    queue_op(CMD_RACK, 8'h01, 1'b1, 1'b0);
    queue_op(REQ_NOP, 8'hFE, 1'b0, 1'b1);
    queue_op(REQ_TICK, 8'h00, 1'b1, 1'b0);
    // drop below the elapsed count mid phase
    write_ticks(16'd3);
    repeat (7) queue_filler();
    write_ticks(16'd0);
    queue_op(CMD_RACK, 8'h00, 1'b1, 1'b1);
    repeat (4) queue_op(REQ_TICK, 8'h00, 1'b1, 1'b0);
    queue_op(CMD_STOP, 8'hFF, 1'b0, 1'b0);
    repeat (3) queue_op(REQ_TICK, 8'hFF, 1'b0, 1'b1);

    write_ticks(16'd1);
    queue_traffic(150, 16'd1);
    write_ticks(16'd2);
    set_idling(57, 0);
    queue_traffic(150, 16'd2);
    write_ticks(16'd1);
    set_idling(0, 57);
    queue_traffic(150, 16'd1);
    write_ticks(16'd3);
    set_idling(17, 17);
    queue_traffic(150, 16'd3);
    write_ticks(16'hFFFF);
    queue_op(CMD_SEND, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat (20) queue_filler();
    write_ticks(16'd2);
    set_idling(0, 0);
    queue_traffic(150, 16'd2);
    settle();

    if (line_results_due.size() != 0)
      report($sformatf("%0d expected results never arrived", line_results_due.size()));
    $display("checked %0d line transfers across %0d phase_ticks writes and four idling modes",
             lines_seen, settings_used);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS i2c_bit_level_master");
    end else begin
      $display("FAIL i2c_bit_level_master");
    end
    $finish;
  end

endmodule
